FILE: hw/rtl/tpdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpdf_pkg
// Shared constants and types for the tpdf dither requantizer: generator
// coefficients, reset values, register map and the configuration bundle.
// ----------------------------------------------------------------------------
package tpdf_pkg;

    // default number of fraction bits on the incoming sample
    localparam int FRAC_BITS_DEF = 16;

    // field widths
    localparam int SAMPLE_W = 32;
    localparam int PCM_W    = 16;
    localparam int GAIN_W   = 15;
    localparam int SEED_W   = 32;
    localparam int RND_W    = 16;
    localparam int DITH_W   = RND_W + 1;

    // shared multiplier operand widths (signed)
    localparam int MUL_A_W = SAMPLE_W + 1;
    localparam int MUL_B_W = 22;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int GPROD_W = SAMPLE_W + GAIN_W;

    // linear congruential generator
    localparam logic [MUL_B_W-1:0] LCG_MUL = 22'd1664525;
    localparam logic [SEED_W-1:0]  LCG_ADD = 32'd1013904223;

    // register reset values
    localparam logic [SEED_W-1:0] SEED_RESET = 32'h1234_5678;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd32022;

    // apb register map, selected by address bit 2
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_GAIN = 1'b0;
    localparam logic REG_SEED = 1'b1;

    // configuration bundle from the register block to the datapath
    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic              seed_load;
        logic [SEED_W-1:0] seed;
    } t_cfg;

endpackage
`default_nettype wire

FILE: hw/rtl/tpdf_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpdf_mul
// Shared signed multiplier with a registered product. Serves both generator
// steps and the gain multiply under control of the sequencer.
// ----------------------------------------------------------------------------
module tpdf_mul (
    input  wire                                   i_clk,
    input  wire                                   i_en,
    input  wire logic signed [tpdf_pkg::MUL_A_W-1:0] i_a,
    input  wire logic signed [tpdf_pkg::MUL_B_W-1:0] i_b,
    output logic signed [tpdf_pkg::MUL_P_W-1:0]      o_p
);
    import tpdf_pkg::*;

    logic signed [MUL_P_W-1:0] r_p;
    logic signed [MUL_P_W-1:0] n_p;

    // full-width signed product
    always_comb begin
        n_p = MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    // product register, payload only
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

FILE: hw/rtl/tpdf_apb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpdf_apb
// APB register block: export gain and dither seed. A seed write also pulses
// a load request for the dither generator.
// ----------------------------------------------------------------------------
module tpdf_apb (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     psel,
    input  wire                                     penable,
    input  wire                                     pwrite,
    input  wire logic [tpdf_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [tpdf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tpdf_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready,
    output tpdf_pkg::t_cfg                          o_cfg
);
    import tpdf_pkg::*;

    logic [GAIN_W-1:0] r_gain;
    logic [SEED_W-1:0] r_seed;
    logic              wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite & pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_seed <= SEED_RESET;
        end else if (wr) begin
            case (paddr[2])
                REG_GAIN: r_gain <= pwdata[GAIN_W-1:0];
                REG_SEED: r_seed <= pwdata[SEED_W-1:0];
                default:  r_seed <= r_seed;
            endcase
        end
    end

    // read-back
    always_comb begin
        case (paddr[2])
            REG_GAIN: prdata = APB_DATA_W'(r_gain);
            REG_SEED: prdata = APB_DATA_W'(r_seed);
            default:  prdata = '0;
        endcase
    end

    // seed load goes straight from the write transaction
    assign o_cfg.gain      = r_gain;
    assign o_cfg.seed_load = wr & (paddr[2] == REG_SEED);
    assign o_cfg.seed      = pwdata[SEED_W-1:0];

endmodule
`default_nettype wire

FILE: hw/rtl/tpdf_dither_requantizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpdf_dither_requantizer
// TPDF-dithered requantizer: gain, triangular dither, saturation and
// round-half-away-from-zero to 16-bit PCM.
//
// Usage:
//   Input stream carries one signed fixed-point sample per transaction
//   (FRAC_BITS fraction bits); channels may be interleaved freely.
//   Output stream carries one 16-bit PCM sample per input transaction.
//   APB port sets export gain (0x0) and dither seed (0x4); a seed write
//   reloads the dither generator. Write registers only while idle.
// Sequence:
//   An accepted sample passes the states GEN1, ADV1, GEN2, ADV2, SUM and
//   OUT before the output register fills; one sample is in flight at a
//   time. The sequencer time-shares one multiplier between the two
//   generator steps and the gain multiply.
// Reset:
//   Synchronous, active low. Gain returns to 32022, seed and generator to
//   0x12345678, the output register is emptied.
// Stall:
//   The result is held in an output register. While it waits, the next
//   sample is accepted and processed; it stalls only in its last step until
//   the output register is free.
// ----------------------------------------------------------------------------
module tpdf_dither_requantizer #(
    parameter int FRAC_BITS = tpdf_pkg::FRAC_BITS_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    // input stream: [31:0] sample_in
    input  wire                                     s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [tpdf_pkg::SAMPLE_W-1:0]      s_axis_tdata,
    // output stream: [15:0] pcm_out
    output logic                                    m_axis_tvalid,
    input  wire                                     m_axis_tready,
    output logic [tpdf_pkg::PCM_W-1:0]              m_axis_tdata,
    // configuration
    input  wire                                     psel,
    input  wire                                     penable,
    input  wire                                     pwrite,
    input  wire logic [tpdf_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [tpdf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tpdf_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready
);
    import tpdf_pkg::*;

    // sum carries FRAC_BITS+18 fraction bits
    localparam int SUM_FRAC = FRAC_BITS + 18;
    localparam int VW       = (SUM_FRAC + 18 > 52) ? SUM_FRAC + 18 : 52;
    localparam logic signed [VW-1:0] V_HI   = VW'(32767) <<< SUM_FRAC;
    localparam logic signed [VW-1:0] V_LO   = -(VW'(32768) <<< SUM_FRAC);
    localparam logic signed [VW-1:0] V_HALF = VW'(1) <<< (SUM_FRAC - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GEN1,
        S_ADV1,
        S_GEN2,
        S_ADV2,
        S_SUM,
        S_OUT
    } t_state;

    t_state r_state;

    t_cfg cfg;

    logic [SEED_W-1:0]         r_gen;
    logic [SAMPLE_W-1:0]       r_sample;
    logic [RND_W-1:0]          r_r1;
    logic signed [DITH_W-1:0]  r_dith;
    logic signed [GPROD_W-1:0] r_gprod;
    logic signed [VW-1:0]      r_v;
    logic                      r_out_valid;
    logic [PCM_W-1:0]          r_pcm;

    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic [SEED_W-1:0]         n_gen;
    logic signed [VW-1:0]      n_v;
    logic signed [VW-1:0]      v_gain;
    logic signed [VW-1:0]      v_dith;
    logic signed [VW-1:0]      v_rnd;
    logic                      out_free;

    // configuration registers
    tpdf_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // shared multiplier operand select
    always_comb begin
        mul_en = 1'b0;
        mul_a  = {1'b0, r_gen};
        mul_b  = LCG_MUL;
        case (r_state)
            S_GEN1, S_GEN2: begin
                mul_en = 1'b1;
            end
            S_ADV1: begin
                mul_en = 1'b1;
                mul_a  = {r_sample[SAMPLE_W-1], r_sample};
                mul_b  = {{(MUL_B_W - GAIN_W){1'b0}}, cfg.gain};
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    tpdf_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // generator advance from the registered product
    assign n_gen = mul_p[SEED_W-1:0] + LCG_ADD;

    // exact sum of gained sample and dither, then saturation
    always_comb begin
        v_gain = {{(VW - GPROD_W){r_gprod[GPROD_W-1]}}, r_gprod} <<< 3;
        v_dith = {{(VW - DITH_W){r_dith[DITH_W-1]}}, r_dith} <<< FRAC_BITS;
        n_v    = v_gain + v_dith;
        if (n_v > V_HI) begin
            n_v = V_HI;
        end else if (n_v < V_LO) begin
            n_v = V_LO;
        end
    end

    // round half away from zero as a floor of v + half - sign
    assign v_rnd    = r_v + V_HALF - VW'(r_v[VW-1]);
    assign out_free = !r_out_valid || m_axis_tready;

    // sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_gen       <= SEED_RESET;
        end else begin
            // output register fills from the last step, empties on a transaction
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            // generator: seed load or one step per advance state
            if (cfg.seed_load) begin
                r_gen <= cfg.seed;
            end else if (r_state == S_ADV1 || r_state == S_ADV2) begin
                r_gen <= n_gen;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_sample <= s_axis_tdata;
                        r_state  <= S_GEN1;
                    end
                end
                S_GEN1: begin
                    r_state <= S_ADV1;
                end
                S_ADV1: begin
                    r_r1    <= n_gen[RND_W-1:0];
                    r_state <= S_GEN2;
                end
                S_GEN2: begin
                    r_gprod <= mul_p[GPROD_W-1:0];
                    r_state <= S_ADV2;
                end
                S_ADV2: begin
                    r_dith  <= $signed({1'b0, r_r1}) - $signed({1'b0, n_gen[RND_W-1:0]});
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_v     <= n_v;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_pcm   <= v_rnd[SUM_FRAC + PCM_W - 1:SUM_FRAC];
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_pcm;

endmodule
`default_nettype wire
